>>> hw/rtl/cte_pkg.sv
package cte_pkg;

	localparam int MAX_LEN    = 16;
	localparam int VALUE_BITS = 8;
	localparam int IW         = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int NW         = $clog2(MAX_LEN + 1);
	localparam int ELEM_W     = 8;
	localparam int POS_W      = 4;
	localparam int MODE_W     = 3;
	localparam int BOUND_W    = 8;
	localparam int LEN_W      = 5;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int BRW        = ((VALUE_BITS > BOUND_W) ? VALUE_BITS : BOUND_W) + 1;

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [IW-1:0]         idx_t;
	typedef logic [NW-1:0]         num_t;

	localparam logic [MODE_W-1:0] MODE_INC  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NOND = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ANY  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIST = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PART = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_ELEM  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EXH   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_RESTART, CMD_INIT_DOWN, CMD_INIT_CNT, CMD_SCAN, CMD_CNT,
		CMD_SPLIT, CMD_PK, CMD_PJ, CMD_SWAP, CMD_FLIP_A, CMD_FLIP_B, CMD_IDX0,
		CMD_EMIT, CMD_OUT_EXH, CMD_OUT_EMPTY, CMD_SET_EXH
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_CNT, S_SPLIT, S_PK, S_PJ, S_SWAP, S_FLIP_A, S_FLIP_B,
		S_EMIT, S_FAIL, S_EXH, S_EMPTY
	} state_t;

	typedef struct packed {
		logic              succ;
		logic              fail;
		logic              idx_last;
		logic              pk_found;
		logic              pk_end;
		logic              pj_hit;
		logic              flip_more;
		logic              out_free;
		logic              exh;
		logic              n_zero;
		logic              restart_bad;
		logic [MODE_W-1:0] mode;
	} dp_status_t;

endpackage

>>> hw/rtl/cte_req_if.sv
interface cte_req_if import cte_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

>>> hw/rtl/cte_rsp_if.sv
interface cte_rsp_if import cte_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element;
	logic [POS_W-1:0]  position;
	logic              last;
	logic [STAT_W-1:0] status;

	modport source (output valid, output element, output position, output last,
		output status, input ready);
	modport sink (input valid, input element, input position, input last,
		input status, output ready);
endinterface

>>> hw/rtl/cte_cfg_if.sv
interface cte_cfg_if import cte_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cte_datapath.sv
module cte_datapath import cte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output dp_status_t  status,
	cte_rsp_if.source   rsp,
	cte_cfg_if.sink     cfg
);

	logic [MODE_W-1:0]  mode_q;
	logic [BOUND_W-1:0] bound_q;
	logic [LEN_W-1:0]   len_q;
	val_t               tup_q [MAX_LEN];
	num_t               cnt_q [MAX_LEN];
	logic               exh_q;
	idx_t               idx_q;
	idx_t               k_q;
	idx_t               j_q;
	num_t               lo_q;
	num_t               hi_q;
	logic [BRW-1:0]     brun_q;
	val_t               prev_q;
	logic               have_prev_q;
	val_t               tk_q;
	val_t               tj_q;
	val_t               tmp_q;

	logic               out_valid_q;
	logic [ELEM_W-1:0]  out_elem_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_last_q;
	logic [STAT_W-1:0]  out_stat_q;

	num_t  n;
	idx_t  rd_addr;
	idx_t  hi_m1;
	val_t  cur;
	val_t  vp1_v;
	int    vp1;
	logic  use_inc;
	logic  any_zero;
	logic  scan_succ;
	logic  vin;
	idx_t  cidx;
	num_t  c;
	logic  split_hit;
	logic  split_succ;
	logic  ramp;
	logic  idx_zero;

	assign n = (int'(len_q) > MAX_LEN) ? NW'(MAX_LEN) : NW'(len_q);
	assign hi_m1 = IW'(hi_q - 1'b1);

	always_comb begin
		case (cmd)
			CMD_FLIP_A: rd_addr = IW'(lo_q);
			CMD_FLIP_B: rd_addr = hi_m1;
			default:    rd_addr = idx_q;
		endcase
	end

	assign cur      = tup_q[rd_addr];
	assign vp1      = int'(cur) + 1;
	assign vp1_v    = VALUE_BITS'(vp1);
	assign idx_zero = (idx_q == '0);
	assign use_inc  = (mode_q == MODE_INC) || (mode_q == MODE_DIST);
	assign any_zero = (mode_q == MODE_ANY) && (bound_q == '0);

	always_comb begin
		if (use_inc) begin
			scan_succ = vp1 < int'(brun_q);
		end else if (mode_q == MODE_ANY) begin
			scan_succ = !any_zero && (vp1 < int'(bound_q));
		end else begin
			scan_succ = vp1 < int'(bound_q);
		end
	end

	assign vin        = int'(cur) < int'(n);
	assign cidx       = IW'(cur);
	assign c          = cnt_q[cidx];
	assign split_hit  = vin && (c != '0);
	assign split_succ = split_hit && (c != NW'(1));
	assign ramp       = (mode_q == MODE_INC) || (mode_q == MODE_DIST);

	always_comb begin
		status = '0;
		status.succ        = (mode_q == MODE_PART) ? split_succ : scan_succ;
		status.fail        = (mode_q == MODE_PART) ? (!split_succ && idx_zero)
		                   : (!scan_succ && (idx_zero || any_zero));
		status.idx_last    = int'(idx_q) == int'(n) - 1;
		status.pk_found    = have_prev_q && (cur < prev_q);
		status.pk_end      = !(have_prev_q && (cur < prev_q)) && idx_zero;
		status.pj_hit      = cur > tk_q;
		status.flip_more   = int'(lo_q) + 1 < int'(hi_q);
		status.out_free    = !out_valid_q || rsp.ready;
		status.exh         = exh_q;
		status.n_zero      = (n == '0);
		status.mode        = mode_q;
		if (ramp) begin
			status.restart_bad = int'(n) > int'(bound_q);
		end else if ((mode_q == MODE_NOND) || (mode_q == MODE_ANY)) begin
			status.restart_bad = (bound_q == '0) && (n != '0);
		end else begin
			status.restart_bad = mode_q > MODE_PART;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			bound_q <= '0;
			len_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:   mode_q  <= MODE_W'(cfg.data);
				REG_BOUND:  bound_q <= BOUND_W'(cfg.data);
				REG_LENGTH: len_q   <= LEN_W'(cfg.data);
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_LEN; j++) begin
				tup_q[j] <= '0;
				cnt_q[j] <= '0;
			end
			exh_q       <= 1'b1;
			idx_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			brun_q      <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			tk_q        <= '0;
			tj_q        <= '0;
			tmp_q       <= '0;
		end else begin
			case (cmd)
				CMD_RESTART: begin
					for (int j = 0; j < MAX_LEN; j++) begin
						tup_q[j] <= (ramp && (j < int'(n))) ? VALUE_BITS'(j) : '0;
					end
					exh_q <= status.restart_bad;
					idx_q <= '0;
				end
				CMD_INIT_DOWN: begin
					idx_q       <= IW'(n - 1'b1);
					brun_q      <= BRW'(bound_q);
					have_prev_q <= 1'b0;
				end
				CMD_INIT_CNT: begin
					idx_q <= '0;
					for (int j = 0; j < MAX_LEN; j++) begin
						cnt_q[j] <= '0;
					end
				end
				CMD_SCAN: begin
					if (use_inc) begin
						if (scan_succ) begin
							for (int j = 0; j < MAX_LEN; j++) begin
								if ((j >= int'(idx_q)) && (j < int'(n))) begin
									tup_q[j] <= VALUE_BITS'(vp1 + j - int'(idx_q));
								end
							end
						end else begin
							brun_q <= BRW'(cur);
						end
					end else if (mode_q == MODE_ANY) begin
						if (!any_zero) begin
							tup_q[idx_q] <= scan_succ ? vp1_v : '0;
						end
					end else if (scan_succ) begin
						for (int j = 0; j < MAX_LEN; j++) begin
							if ((j >= int'(idx_q)) && (j < int'(n))) begin
								tup_q[j] <= vp1_v;
							end
						end
					end
					if (scan_succ) begin
						idx_q <= '0;
					end else if (!idx_zero) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				CMD_CNT: begin
					if (vin) begin
						cnt_q[cidx] <= c + 1'b1;
					end
					if (status.idx_last) begin
						idx_q <= IW'(n - 1'b1);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_SPLIT: begin
					if (split_hit) begin
						cnt_q[cidx] <= c - 1'b1;
					end
					if (split_succ) begin
						for (int j = 0; j < MAX_LEN; j++) begin
							if ((j > int'(idx_q)) && (j < int'(n))) begin
								tup_q[j] <= '0;
							end
						end
						tup_q[idx_q] <= vp1_v;
						idx_q <= '0;
					end else if (!idx_zero) begin
						idx_q <= idx_q - 1'b1;
					end
				end
				CMD_PK: begin
					if (status.pk_found) begin
						k_q   <= idx_q;
						tk_q  <= cur;
						idx_q <= IW'(n - 1'b1);
					end else if (idx_zero) begin
						lo_q <= '0;
						hi_q <= n;
					end else begin
						prev_q      <= cur;
						have_prev_q <= 1'b1;
						idx_q       <= idx_q - 1'b1;
					end
				end
				CMD_PJ: begin
					if (status.pj_hit) begin
						j_q  <= idx_q;
						tj_q <= cur;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				CMD_SWAP: begin
					tup_q[k_q] <= tj_q;
					tup_q[j_q] <= tk_q;
					lo_q       <= NW'(k_q) + 1'b1;
					hi_q       <= n;
				end
				CMD_FLIP_A: tmp_q <= cur;
				CMD_FLIP_B: begin
					tup_q[IW'(lo_q)] <= cur;
					tup_q[hi_m1]     <= tmp_q;
					lo_q             <= lo_q + 1'b1;
					hi_q             <= hi_q - 1'b1;
				end
				CMD_IDX0: idx_q <= '0;
				CMD_EMIT: begin
					if (!status.idx_last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				CMD_SET_EXH: exh_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd == CMD_EMIT) || (cmd == CMD_OUT_EXH) || (cmd == CMD_OUT_EMPTY)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_EMIT: begin
				out_elem_q <= ELEM_W'(cur);
				out_pos_q  <= POS_W'(idx_q);
				out_last_q <= status.idx_last;
				out_stat_q <= STAT_ELEM;
			end
			CMD_OUT_EXH, CMD_OUT_EMPTY: begin
				out_elem_q <= '0;
				out_pos_q  <= '0;
				out_last_q <= 1'b1;
				out_stat_q <= (cmd == CMD_OUT_EXH) ? STAT_EXH : STAT_EMPTY;
			end
			default: ;
		endcase
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.element  = out_elem_q;
	assign rsp.position = out_pos_q;
	assign rsp.last     = out_last_q;
	assign rsp.status   = out_stat_q;

endmodule

>>> hw/rtl/cte_ctrl.sv
module cte_ctrl import cte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output cmd_t       cmd,
	cte_req_if.sink    req
);

	state_t state_q;
	state_t state_d;
	logic   found_q;

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_SWAP) begin
				found_q <= 1'b1;
			end else if ((cmd == CMD_PK) && status.pk_end) begin
				found_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.restart) begin
						if (status.restart_bad) begin
							state_d = S_EXH;
						end else if (status.n_zero) begin
							state_d = S_EMPTY;
						end else begin
							state_d = S_EMIT;
						end
					end else if (status.exh) begin
						state_d = S_EXH;
					end else if (status.n_zero || (status.mode > MODE_PART)) begin
						state_d = S_FAIL;
					end else if (status.mode == MODE_DIST) begin
						state_d = S_PK;
					end else if (status.mode == MODE_PART) begin
						state_d = S_CNT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN, S_SPLIT: begin
				if (status.succ) begin
					state_d = S_EMIT;
				end else if (status.fail) begin
					state_d = S_FAIL;
				end
			end
			S_CNT: if (status.idx_last) state_d = S_SPLIT;
			S_PK: begin
				if (status.pk_found) begin
					state_d = S_PJ;
				end else if (status.pk_end) begin
					state_d = S_FLIP_A;
				end
			end
			S_PJ: if (status.pj_hit) state_d = S_SWAP;
			S_SWAP: state_d = S_FLIP_A;
			S_FLIP_A: begin
				if (status.flip_more) begin
					state_d = S_FLIP_B;
				end else if (found_q) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_FLIP_B: state_d = S_FLIP_A;
			S_EMIT: if (status.out_free && status.idx_last) state_d = S_IDLE;
			S_FAIL: state_d = S_EXH;
			S_EXH, S_EMPTY: if (status.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.restart) begin
						cmd = CMD_RESTART;
					end else if (status.exh || status.n_zero || (status.mode > MODE_PART)) begin
						cmd = CMD_NONE;
					end else if (status.mode == MODE_PART) begin
						cmd = CMD_INIT_CNT;
					end else begin
						cmd = CMD_INIT_DOWN;
					end
				end
			end
			S_SCAN:   cmd = CMD_SCAN;
			S_SPLIT:  cmd = CMD_SPLIT;
			S_CNT:    cmd = CMD_CNT;
			S_PK:     cmd = CMD_PK;
			S_PJ:     cmd = CMD_PJ;
			S_SWAP:   cmd = CMD_SWAP;
			S_FLIP_A: begin
				if (status.flip_more) begin
					cmd = CMD_FLIP_A;
				end else if (found_q) begin
					cmd = CMD_IDX0;
				end else begin
					cmd = CMD_INIT_DOWN;
				end
			end
			S_FLIP_B: cmd = CMD_FLIP_B;
			S_EMIT:   if (status.out_free) cmd = CMD_EMIT;
			S_FAIL:   cmd = CMD_SET_EXH;
			S_EXH:    if (status.out_free) cmd = CMD_OUT_EXH;
			S_EMPTY:  if (status.out_free) cmd = CMD_OUT_EMPTY;
			default:  cmd = CMD_NONE;
		endcase
	end

endmodule

>>> hw/rtl/combinatorial_tuple_enumerator.sv
// Channel  Role    Payload                                  Handshake
// req      sink    restart                                  valid/ready
// rsp      source  element, position, last, status          valid/ready
// cfg      sink    index (0 mode, 1 bound, 2 length), data  valid/ready, always ready
//
// One request word is taken at a time; ready is high only while the controller is idle.
// An advance walks the tuple one element per cycle, and partition mode first counts
// the values in a pass of its own. Distinct mode searches for the pivot and its swap
// partner, swaps, reverses the tail a pair at a time, and on wrap goes on to the
// increasing scan. One response word then leaves per cycle while the response port
// accepts it. A stalled response port holds the emitter in place.
// Reset clears the tuple and marks the enumeration exhausted until a restart.
module combinatorial_tuple_enumerator import cte_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cte_req_if.sink   req,
	cte_rsp_if.source rsp,
	cte_cfg_if.sink   cfg
);

	// Commands flow from the controller to the datapath; status comes back.
	cmd_t       cmd;
	dp_status_t status;

	cte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd),
		.req    (req)
	);

	// The datapath holds the tuple, the scratch counts, the configuration and
	// the output word register.
	cte_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

>>> tb/sv/combinatorial_tuple_enumerator_tb.sv
module combinatorial_tuple_enumerator_tb;
	import cte_pkg::*;

	// One expected response word.
	typedef struct {
		logic [ELEM_W-1:0] element;
		logic [POS_W-1:0]  position;
		logic              last;
		logic [STAT_W-1:0] status;
	} rsp_word_t;

	// Tracks the enumerator state and holds the response words that are still due.
	class tuple_scoreboard;
		logic [VALUE_BITS-1:0] tup [MAX_LEN];
		bit                    done;
		logic [MODE_W-1:0]     mode;
		logic [BOUND_W-1:0]    bound;
		logic [LEN_W-1:0]      length;
		rsp_word_t             due [$];
		int                    errors;

		function new();
			foreach (tup[i]) tup[i] = '0;
			done = 1'b1;
			mode = '0;
			bound = '0;
			length = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MODE:   mode = data[MODE_W-1:0];
				REG_BOUND:  bound = data[BOUND_W-1:0];
				REG_LENGTH: length = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_single(logic [STAT_W-1:0] st);
			rsp_word_t w;
			w.element = '0;
			w.position = '0;
			w.last = 1'b1;
			w.status = st;
			due.push_back(w);
		endfunction

		function void push_tuple(int n);
			rsp_word_t w;
			if (n == 0) begin
				push_single(STAT_EMPTY);
				return;
			end
			for (int k = 0; k < n; k++) begin
				w.element = tup[k];
				w.position = k[POS_W-1:0];
				w.last = (k == n - 1);
				w.status = STAT_ELEM;
				due.push_back(w);
			end
		endfunction

		function bit next_combination(int n, int b);
			int v;
			for (int i = n - 1; i >= 0; i--) begin
				v = int'(tup[i]);
				if (v + 1 < b) begin
					for (int j = i; j < n; j++) tup[j] = VALUE_BITS'(v + 1 + j - i);
					return 1'b1;
				end
				b = v;
			end
			return 1'b0;
		endfunction

		function bit next_multiset(int n, int b);
			int v;
			for (int i = n - 1; i >= 0; i--) begin
				v = int'(tup[i]);
				if (v < b - 1) begin
					for (int j = i; j < n; j++) tup[j] = VALUE_BITS'(v + 1);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit next_odometer(int n, int b);
			int v;
			if (b == 0) return 1'b0;
			for (int i = n - 1; i >= 0; i--) begin
				v = int'(tup[i]) + 1;
				if (v >= b) tup[i] = '0;
				else begin
					tup[i] = VALUE_BITS'(v);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void reverse(int lo, int hi);
			logic [VALUE_BITS-1:0] t;
			while (lo + 1 < hi) begin
				t = tup[lo];
				tup[lo] = tup[hi - 1];
				tup[hi - 1] = t;
				lo++;
				hi--;
			end
		endfunction

		function bit next_ordering(int n);
			int k;
			int j;
			logic [VALUE_BITS-1:0] t;
			k = -1;
			for (int i = n - 1; i > 0; i--) begin
				if (tup[i - 1] < tup[i]) begin
					k = i - 1;
					break;
				end
			end
			if (k < 0) begin
				reverse(0, n);
				return 1'b0;
			end
			j = n - 1;
			while (tup[j] <= tup[k]) j--;
			t = tup[k];
			tup[k] = tup[j];
			tup[j] = t;
			reverse(k + 1, n);
			return 1'b1;
		endfunction

		function bit next_partition(int n);
			int cnt [MAX_LEN];
			int v;
			foreach (cnt[i]) cnt[i] = 0;
			for (int i = 0; i < n; i++)
				if (int'(tup[i]) < n) cnt[tup[i]]++;
			for (int i = n - 1; i >= 0; i--) begin
				v = int'(tup[i]);
				if (v < n && cnt[v] > 0) begin
					cnt[v]--;
					if (cnt[v] != 0) begin
						tup[i] = VALUE_BITS'(v + 1);
						for (int j = i + 1; j < n; j++) tup[j] = '0;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		// Notes one accepted request word and queues the words it must produce.
		function void note_request(bit restart);
			int n;
			bit ramp;
			bit bad;
			bit ok;
			n = (int'(length) > MAX_LEN) ? MAX_LEN : int'(length);
			if (restart) begin
				ramp = (mode == MODE_INC) || (mode == MODE_DIST);
				for (int i = 0; i < MAX_LEN; i++) tup[i] = (ramp && i < n) ? VALUE_BITS'(i) : '0;
				if (ramp) bad = n > int'(bound);
				else if (mode == MODE_NOND || mode == MODE_ANY) bad = (bound == 0) && (n > 0);
				else bad = mode > MODE_PART;
				done = bad;
				if (bad) push_single(STAT_EXH);
				else push_tuple(n);
				return;
			end
			if (done) begin
				push_single(STAT_EXH);
				return;
			end
			case (mode)
				MODE_INC:  ok = next_combination(n, int'(bound));
				MODE_NOND: ok = next_multiset(n, int'(bound));
				MODE_ANY:  ok = next_odometer(n, int'(bound));
				MODE_DIST: ok = next_ordering(n) || next_combination(n, int'(bound));
				MODE_PART: ok = next_partition(n);
				default:   ok = 1'b0;
			endcase
			if (!ok) begin
				done = 1'b1;
				push_single(STAT_EXH);
			end else begin
				push_tuple(n);
			end
		endfunction

		function void check_word(rsp_word_t got);
			rsp_word_t exp;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word element=%0d position=%0d last=%0d status=%0d",
					$time, got.element, got.position, got.last, got.status);
				return;
			end
			exp = due.pop_front();
			if (got.element !== exp.element) begin
				errors++;
				$display("%0t: element expected %0d actual %0d", $time, exp.element, got.element);
			end
			if (got.position !== exp.position) begin
				errors++;
				$display("%0t: position expected %0d actual %0d", $time, exp.position,
					got.position);
			end
			if (got.last !== exp.last) begin
				errors++;
				$display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
			end
			if (got.status !== exp.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 1000000;
	// Settling time after the last due word; leave plenty of margin.
	localparam int SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	int   cycles;
	int   src_idle;
	int   snk_idle;
	bit   hold_req;
	tuple_scoreboard sb;

	cte_req_if req_ch ();
	cte_rsp_if rsp_ch ();
	cte_cfg_if cfg_ch ();

	combinatorial_tuple_enumerator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The cycle counter doubles as the watchdog for the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("combinatorial_tuple_enumerator test failed");
			$finish;
		end
	end

	// Response side. Values read right at the edge are the ones the handshake saw.
	// The ready for the next cycle is drawn from the current stall rate, unless a long
	// hold-off has been asked for, which this process counts down by itself.
	initial begin : response_side
		int hold_left;
		rsp_word_t got;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.element = rsp_ch.element;
				got.position = rsp_ch.position;
				got.last = rsp_ch.last;
				got.status = rsp_ch.status;
				sb.check_word(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
			end
		end
	end

	// Offers one request word, with random idle cycles in front of it. Valid stays high
	// after acceptance so back-to-back words never drop it within one step.
	task automatic send_request(bit restart);
		while ($urandom_range(0, 99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(restart);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every due word has arrived, then lets the controller settle back to
	// idle before anything touches the configuration.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reconfigures the idle block. Spare upper data bits are filled at random so that
	// every bit of the write data toggles; the block keeps only the field widths.
	task automatic configure(int m, int b, int len);
		drain();
		write_reg(REG_MODE, {5'($urandom_range(0, 31)), 3'(m)});
		write_reg(REG_BOUND, 8'(b));
		write_reg(REG_LENGTH, {3'($urandom_range(0, 7)), 5'(len)});
	endtask

	task automatic run_steps(int advances);
		send_request(1'b1);
		repeat (advances) send_request(1'b0);
	endtask

	// A random setting: mostly short tuples over small ranges so enumerations finish and
	// wrap often, now and then the extremes of bound and length.
	task automatic random_phase(int items);
		int m;
		int b;
		int len;
		m = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
		b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
		case ($urandom_range(0, 9))
			0: len = 16;
			1: len = $urandom_range(17, 31);
			default: len = $urandom_range(0, 5);
		endcase
		configure(m, b, len);
		// Usually start fresh, but sometimes carry on from the old tuple under the new
		// settings, which the block must also handle.
		if ($urandom_range(0, 3) != 0) send_request(1'b1);
		repeat (items) send_request($urandom_range(0, 11) == 0);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		src_idle = 0;
		snk_idle = 0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.restart <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_MODE;
		cfg_ch.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Right after reset the block is exhausted, so an advance
		// must report that before any restart.
		send_request(1'b0);
		configure(MODE_INC, 5, 3);
		run_steps(3);
		// Distinct mode steps through orderings of the one combination that bound 3 allows.
		configure(MODE_DIST, 3, 3);
		run_steps(4);
		configure(MODE_PART, 0, 3);
		run_steps(4);
		// The odometer runs out quickly and then reports exhaustion.
		configure(MODE_ANY, 2, 2);
		run_steps(4);
		configure(MODE_NOND, 255, 16);
		run_steps(1);
		// Empty tuple first, then exhaustion on the next advance.
		configure(MODE_ANY, 0, 0);
		run_steps(1);
		// Bound of zero, length above bound, a mode code past the last one, and a
		// length past the tuple size that must saturate.
		configure(MODE_NOND, 0, 2);
		run_steps(0);
		configure(MODE_INC, 2, 3);
		run_steps(0);
		configure(7, 255, 31);
		run_steps(0);
		configure(MODE_ANY, 255, 31);
		run_steps(1);

		// Random part, first with a slow receiver. Early on the receiver holds off for
		// a long stretch while words keep coming, so the block backs up.
		src_idle = 14;
		snk_idle = 81;
		configure(MODE_ANY, 3, 4);
		send_request(1'b1);
		hold_req = 1'b1;
		repeat (6) send_request(1'b0);
		repeat (3) random_phase(6);
		// Then a slow sender.
		src_idle = 81;
		snk_idle = 14;
		repeat (3) random_phase(6);
		// Pause until everything is back before sending on.
		drain();
		src_idle = 0;
		snk_idle = 0;
		repeat (3) random_phase(6);
		drain();

		if (sb.errors == 0) begin
			$display("combinatorial_tuple_enumerator test passed");
		end else begin
			$display("combinatorial_tuple_enumerator test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/cte_pkg.sv
hw/rtl/cte_req_if.sv
hw/rtl/cte_rsp_if.sv
hw/rtl/cte_cfg_if.sv
hw/rtl/cte_datapath.sv
hw/rtl/cte_ctrl.sv
hw/rtl/combinatorial_tuple_enumerator.sv
tb/sv/combinatorial_tuple_enumerator_tb.sv
